@@ sv/rtp_pkg.sv @@
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types and constants for the range to prefix expander.
// ----------------------------------------------------------------------------
package rtp_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int K_W    = $clog2(ADDR_W + 1);

    typedef struct packed {
        logic [ADDR_W-1:0] range_low;
        logic [ADDR_W-1:0] range_high;
    } t_range;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix_base;
        logic [LEN_W-1:0]  prefix_length;
        logic              last_prefix;
    } t_prefix;

    typedef enum logic {
        STEP_GROW,
        STEP_NEXT
    } t_step_op;

    typedef struct packed {
        logic              grow_ok;
        logic              last;
        logic [ADDR_W-1:0] next_addr;
    } t_step_res;

endpackage

@@ sv/range_to_prefix_expander.sv @@
// ----------------------------------------------------------------------------
// range_to_prefix_expander
// Splits an inclusive address range into the fewest aligned prefixes,
// walking up from the low end, one base and length pair per transfer.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   in      | i_in_valid, o_in_ready | i_in  : range_low, range_high
//   out     | o_out_valid, i_out_ready| o_out : prefix_base, prefix_length,
//           |                        |         last_prefix
//
// A prefix of 2^k addresses is found by one grow test a cycle in the
// shared add/compare unit, then a push step works out the next address.
// An empty range is taken in idle and starts no walk.
// o_in_ready is high only while no range is being walked.
// A stalled output register holds the walk in its push step.
// Synchronous active-low reset empties the output register and idles.
// ----------------------------------------------------------------------------
module range_to_prefix_expander import rtp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_range  i_in,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_prefix o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROW,
        S_PUSH
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_cursor, n_cursor;
    logic [ADDR_W-1:0] r_bound, n_bound;
    logic [ADDR_W-1:0] r_span, n_span;
    logic [K_W-1:0]    r_k, n_k;
    logic              r_out_valid, n_out_valid;
    t_prefix           r_out, n_out;

    t_step_op          w_op;
    t_step_res         w_res;

    assign w_op = (r_state == S_PUSH) ? STEP_NEXT : STEP_GROW;

    rtp_step_unit u_step (
        .i_op     (w_op),
        .i_cursor (r_cursor),
        .i_bound  (r_bound),
        .i_span   (r_span),
        .i_k      (r_k),
        .o_res    (w_res)
    );

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_bound     = r_bound;
        n_span      = r_span;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cursor = i_in.range_low;
                    n_bound  = i_in.range_high;
                    n_span   = '0;
                    n_k      = '0;
                    if (i_in.range_low <= i_in.range_high) begin
                        n_state = S_GROW;
                    end
                end
            end
            S_GROW: begin
                if (w_res.grow_ok) begin
                    n_span = {r_span[ADDR_W-2:0], 1'b1};
                    n_k    = r_k + K_W'(1);
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid         = 1'b1;
                    n_out.prefix_base   = r_cursor;
                    n_out.prefix_length = LEN_W'(ADDR_W) - LEN_W'(r_k);
                    n_out.last_prefix   = w_res.last;
                    n_cursor            = w_res.next_addr;
                    n_span              = '0;
                    n_k                 = '0;
                    n_state             = w_res.last ? S_IDLE : S_GROW;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_bound     <= '0;
            r_span      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_bound     <= n_bound;
            r_span      <= n_span;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // prefix base aligned to its length
    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out.prefix_base & ({ADDR_W{1'b1}} >> o_out.prefix_length)) == '0))
        else $error("prefix base not aligned");

    // length within the address width
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.prefix_length <= LEN_W'(ADDR_W)))
        else $error("prefix length out of range");

    // grow counter never passes the address width
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GROW) |-> (r_k <= K_W'(ADDR_W)))
        else $error("block size counter overrun");

    // a non-empty range starts a walk
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in.range_low <= i_in.range_high))
            |=> !o_in_ready)
        else $error("walk did not start");

endmodule

@@ sv/rtp_step_unit.sv @@
// ----------------------------------------------------------------------------
// rtp_step_unit
// Shared add and compare unit: tests a larger block at the cursor, or
// works out the address after the chosen block and whether the walk ends.
// ----------------------------------------------------------------------------
module rtp_step_unit import rtp_pkg::*; (
    input  t_step_op          i_op,
    input  logic [ADDR_W-1:0] i_cursor,
    input  logic [ADDR_W-1:0] i_bound,
    input  logic [ADDR_W-1:0] i_span,
    input  logic [K_W-1:0]    i_k,
    output t_step_res         o_res
);

    logic [ADDR_W-1:0] w_operand;
    logic              w_cin;
    logic [ADDR_W:0]   w_sum;
    logic              w_within;
    logic              w_k_full;

    always_comb begin
        if (i_op == STEP_NEXT) begin
            w_operand = i_span;
            w_cin     = 1'b1;
        end else begin
            w_operand = {i_span[ADDR_W-2:0], 1'b1};
            w_cin     = 1'b0;
        end
        w_sum    = {1'b0, i_cursor} + {1'b0, w_operand} + (ADDR_W+1)'(w_cin);
        w_within = !w_sum[ADDR_W] && (w_sum[ADDR_W-1:0] <= i_bound);
        w_k_full = (i_k == K_W'(ADDR_W));

        o_res.grow_ok   = !w_k_full && !i_cursor[i_k[K_W-2:0]] && w_within;
        o_res.last      = !w_within;
        o_res.next_addr = w_sum[ADDR_W-1:0];
    end

endmodule
